/* hw/rtl/hhdm_pkg.sv */
package hhdm_pkg;

   // field widths
   localparam int GAIN_W  = 6;
   localparam int BAND_W  = 9;
   localparam int STICK_W = 11;
   localparam int YAW_W   = 9;
   localparam int PWM_W   = 11;

   // stick minus center, signed
   localparam int DEV_W   = STICK_W + 1;
   // roll deviation after the heading gain, signed
   localparam int ROLL_W  = 16;
   // motor value before and after the clamp, signed
   localparam int SUM_W   = 14;
   localparam int MOTOR_W = 10;

   // stream payload widths
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 24;

   localparam logic signed [DEV_W-1:0]   STICK_CENTER = 12'sd1500;
   localparam logic signed [YAW_W:0]     HALF_TURN    = 10'sd180;
   localparam logic signed [YAW_W:0]     FULL_TURN    = 10'sd360;
   localparam logic signed [SUM_W-1:0]   MOTOR_LIMIT  = 14'sd500;
   localparam logic [PWM_W-1:0]          PWM_BASE     = 11'd1000;

   // divide by three: floor(a / 3) = (a * RECIP3) >> RECIP3_SHIFT for a < 2**17
   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;
   localparam int          QUOT_W       = 12;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd10;
   localparam logic [BAND_W-1:0] BAND_RESET = 9'd30;

   typedef enum logic [0:0] {
      CSR_HEADING_GAIN   = 1'b0,
      CSR_STICK_DEADBAND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                      armed;
      logic                      hold;
      logic signed [YAW_W-1:0]   err;
      logic signed [DEV_W-1:0]   roll_dev;
      logic signed [DEV_W-1:0]   thr_dev;
   } front_type;

   typedef struct packed {
      logic                      armed;
      logic signed [ROLL_W-1:0]  roll_dev;
      logic signed [DEV_W-1:0]   thr_dev;
   } gain_type;

   typedef struct packed {
      logic                      right_reverse;
      logic                      left_reverse;
      logic [PWM_W-1:0]          right_pwm;
      logic [PWM_W-1:0]          left_pwm;
   } result_type;

endpackage

/* hw/rtl/heading_hold_differential_mixer_core.sv */
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+----------------------------------------
// req_      | in  | req_tvalid/req_tready  | stick, yaw and flag fields, one tick
// rsp_      | out | rsp_tvalid/rsp_tready  | left/right pwm and reverse bits
// csr_      | in  | csr_wen (no handshake) | heading_gain, stick_deadband
//
// one transaction per clock sustained while rsp_ is not stalled; a request passes three
// registers on its way to rsp_ (input register, gain product register, output register)
// the gain multiply and the divide-by-three reciprocal multiply set the stage split
// synchronous active-high reset: config back to gain 10 / deadband 30, target
// heading and held direction bits cleared, pipeline emptied
// a stall on rsp_ backs up stage by stage; req_tready drops only when all three are full
module heading_hold_differential_mixer_core (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [0] start_pilot, [1] armed, [12:2] roll_stick, [23:13] throttle_stick,
   // [32:24] yaw_angle, [39:33] zero
   input  logic [hhdm_pkg::REQ_W-1:0]  req_tdata,

   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [10:0] left_pwm, [21:11] right_pwm, [22] left_reverse, [23] right_reverse
   output logic [hhdm_pkg::RSP_W-1:0]  rsp_tdata,

   input  logic                        csr_wen,
   input  logic [0:0]                  csr_index,
   input  logic [hhdm_pkg::BAND_W-1:0] csr_wdata
);

   logic [hhdm_pkg::GAIN_W-1:0]  heading_gain_ff;
   logic [hhdm_pkg::BAND_W-1:0]  stick_deadband_ff;

   // stage links
   logic                         front_valid;
   logic                         front_ready;
   hhdm_pkg::front_type          front_data;
   logic                         gain_valid;
   logic                         gain_ready;
   hhdm_pkg::gain_type           gain_data;
   hhdm_pkg::result_type         result;

   // configuration registers, written only while the pipeline is idle (the user's rule, not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_gain_ff   <= hhdm_pkg::GAIN_RESET;
         stick_deadband_ff <= hhdm_pkg::BAND_RESET;
      end else if (csr_wen) begin
         unique case (hhdm_pkg::csr_index_type'(csr_index))
            hhdm_pkg::CSR_HEADING_GAIN: begin
               heading_gain_ff <= csr_wdata[hhdm_pkg::GAIN_W-1:0];
            end
            hhdm_pkg::CSR_STICK_DEADBAND: begin
               stick_deadband_ff <= csr_wdata;
            end
         endcase
      end
   end

   // input stage: target heading tracking, heading error wrap, deadband test
   hhdm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .stick_deadband (stick_deadband_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .start_pilot    (req_tdata[0]),
      .armed          (req_tdata[1]),
      .roll_stick     (req_tdata[12:2]),
      .throttle_stick (req_tdata[23:13]),
      .yaw_angle      ($signed(req_tdata[32:24])),
      .out_valid      (front_valid),
      .out_ready      (front_ready),
      .out_data       (front_data)
   );

   // gain stage: proportional correction replaces the stick inside the deadband
   hhdm_gain u_gain (
      .clock        (clock),
      .reset        (reset),
      .heading_gain (heading_gain_ff),
      .in_valid     (front_valid),
      .in_ready     (front_ready),
      .in_data      (front_data),
      .out_valid    (gain_valid),
      .out_ready    (gain_ready),
      .out_data     (gain_data)
   );

   // mix stage: split roll over both motors, clamp, pwm and direction
   hhdm_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gain_valid),
      .in_ready  (gain_ready),
      .in_data   (gain_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = result;

endmodule

/* hw/rtl/hhdm_front.sv */
module hhdm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [hhdm_pkg::BAND_W-1:0]       stick_deadband,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              start_pilot,
   input  logic                              armed,
   input  logic [hhdm_pkg::STICK_W-1:0]      roll_stick,
   input  logic [hhdm_pkg::STICK_W-1:0]      throttle_stick,
   input  logic signed [hhdm_pkg::YAW_W-1:0] yaw_angle,
   output logic                              out_valid,
   input  logic                              out_ready,
   output hhdm_pkg::front_type               out_data
);

   logic                                valid_ff;
   hhdm_pkg::front_type                 data_ff;
   hhdm_pkg::front_type                 data_in;
   logic signed [hhdm_pkg::YAW_W-1:0]   target_ff;
   logic signed [hhdm_pkg::YAW_W-1:0]   target_in;
   logic signed [hhdm_pkg::YAW_W-1:0]   eff_target;
   logic signed [hhdm_pkg::YAW_W:0]     err_raw;
   logic signed [hhdm_pkg::YAW_W:0]     err_wrap;
   logic signed [hhdm_pkg::DEV_W-1:0]   roll_dev;
   logic [hhdm_pkg::STICK_W-1:0]        roll_mag;
   logic                                hold;
   logic                                accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      roll_dev = $signed({1'b0, roll_stick}) - hhdm_pkg::STICK_CENTER;
      roll_mag = roll_dev[hhdm_pkg::DEV_W-1] ? hhdm_pkg::STICK_W'(-roll_dev)
                                             : hhdm_pkg::STICK_W'(roll_dev);
      hold     = roll_mag < {2'b00, stick_deadband};

      // start latches the yaw before anything else
      eff_target = start_pilot ? yaw_angle : target_ff;
      err_raw    = (hhdm_pkg::YAW_W+1)'(eff_target) - (hhdm_pkg::YAW_W+1)'(yaw_angle);
      if (err_raw > hhdm_pkg::HALF_TURN) begin
         err_wrap = err_raw - hhdm_pkg::FULL_TURN;
      end else if (err_raw < -hhdm_pkg::HALF_TURN) begin
         err_wrap = err_raw + hhdm_pkg::FULL_TURN;
      end else begin
         err_wrap = err_raw;
      end

      // start, or a stick outside the deadband while armed is low, retargets to the current yaw
      target_in = (start_pilot || (!armed && !hold)) ? yaw_angle : target_ff;

      data_in.armed    = armed;
      data_in.hold     = hold;
      data_in.err      = hhdm_pkg::YAW_W'(err_wrap);
      data_in.roll_dev = roll_dev;
      data_in.thr_dev  = $signed({1'b0, throttle_stick}) - hhdm_pkg::STICK_CENTER;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         target_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            target_ff <= target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hw/rtl/hhdm_gain.sv */
module hhdm_gain (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hhdm_pkg::GAIN_W-1:0]   heading_gain,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hhdm_pkg::front_type           in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hhdm_pkg::gain_type            out_data
);

   logic                                 valid_ff;
   hhdm_pkg::gain_type                   data_ff;
   hhdm_pkg::gain_type                   data_in;
   logic signed [hhdm_pkg::ROLL_W-1:0]   gain_x;
   logic signed [hhdm_pkg::ROLL_W-1:0]   err_x;
   logic signed [hhdm_pkg::ROLL_W-1:0]   held_roll;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      gain_x    = $signed({{(hhdm_pkg::ROLL_W-hhdm_pkg::GAIN_W){1'b0}}, heading_gain});
      err_x     = hhdm_pkg::ROLL_W'(in_data.err);
      held_roll = gain_x * err_x;

      data_in.armed    = in_data.armed;
      data_in.roll_dev = in_data.hold ? held_roll : hhdm_pkg::ROLL_W'(in_data.roll_dev);
      data_in.thr_dev  = in_data.thr_dev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hw/rtl/hhdm_mix.sv */
module hhdm_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hhdm_pkg::gain_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hhdm_pkg::result_type out_data
);

   localparam int MAG_W  = hhdm_pkg::ROLL_W - 1;
   localparam int PROD_W = MAG_W + 16;

   logic                                 valid_ff;
   hhdm_pkg::result_type                 data_ff;
   hhdm_pkg::result_type                 data_in;
   logic                                 left_held_ff;
   logic                                 right_held_ff;
   logic                                 roll_neg;
   logic [MAG_W-1:0]                     roll_mag;
   logic [PROD_W-1:0]                    recip_prod;
   logic [hhdm_pkg::QUOT_W-1:0]          quot;
   logic signed [hhdm_pkg::QUOT_W:0]     share;
   logic signed [hhdm_pkg::SUM_W-1:0]    left_sum;
   logic signed [hhdm_pkg::SUM_W-1:0]    right_sum;
   logic signed [hhdm_pkg::MOTOR_W-1:0]  left_val;
   logic signed [hhdm_pkg::MOTOR_W-1:0]  right_val;
   logic                                 accept;

   function automatic logic signed [hhdm_pkg::MOTOR_W-1:0] clamp_motor(
      input logic signed [hhdm_pkg::SUM_W-1:0] v
   );
      logic signed [hhdm_pkg::SUM_W-1:0] c;
      if (v > hhdm_pkg::MOTOR_LIMIT) begin
         c = hhdm_pkg::MOTOR_LIMIT;
      end else if (v < -hhdm_pkg::MOTOR_LIMIT) begin
         c = -hhdm_pkg::MOTOR_LIMIT;
      end else begin
         c = v;
      end
      return hhdm_pkg::MOTOR_W'(c);
   endfunction

   function automatic logic [hhdm_pkg::PWM_W-1:0] pwm_of(
      input logic signed [hhdm_pkg::MOTOR_W-1:0] v
   );
      logic [hhdm_pkg::MOTOR_W-2:0] mag;
      mag = v[hhdm_pkg::MOTOR_W-1] ? (hhdm_pkg::MOTOR_W-1)'(-v)
                                   : (hhdm_pkg::MOTOR_W-1)'(v);
      return hhdm_pkg::PWM_BASE + hhdm_pkg::PWM_W'({mag, 1'b0});
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // truncating divide by three on the magnitude, sign put back after
      roll_neg   = in_data.roll_dev[hhdm_pkg::ROLL_W-1];
      roll_mag   = roll_neg ? MAG_W'(-in_data.roll_dev) : MAG_W'(in_data.roll_dev);
      recip_prod = PROD_W'(roll_mag) * PROD_W'(hhdm_pkg::RECIP3);
      quot       = recip_prod[hhdm_pkg::RECIP3_SHIFT +: hhdm_pkg::QUOT_W];
      share      = roll_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

      left_sum   = hhdm_pkg::SUM_W'(in_data.thr_dev) + hhdm_pkg::SUM_W'(share);
      right_sum  = hhdm_pkg::SUM_W'(in_data.thr_dev) - hhdm_pkg::SUM_W'(share);
      left_val   = clamp_motor(left_sum);
      right_val  = clamp_motor(right_sum);

      if (in_data.armed) begin
         data_in.left_pwm      = hhdm_pkg::PWM_BASE;
         data_in.right_pwm     = hhdm_pkg::PWM_BASE;
         data_in.left_reverse  = left_held_ff;
         data_in.right_reverse = right_held_ff;
      end else begin
         data_in.left_pwm      = pwm_of(left_val);
         data_in.right_pwm     = pwm_of(right_val);
         data_in.left_reverse  = left_val[hhdm_pkg::MOTOR_W-1];
         data_in.right_reverse = right_val[hhdm_pkg::MOTOR_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         left_held_ff  <= 1'b0;
         right_held_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            left_held_ff  <= data_in.left_reverse;
            right_held_ff <= data_in.right_reverse;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

/* bench/heading_hold_differential_mixer_core_tb.sv */
`timescale 1ns / 1ps

module heading_hold_differential_mixer_core_tb;

   // mixer constants in plain integer form for the predictor
   localparam int CENTER      = hhdm_pkg::STICK_CENTER;
   localparam int HALF        = hhdm_pkg::HALF_TURN;
   localparam int FULL        = hhdm_pkg::FULL_TURN;
   localparam int LIMIT       = hhdm_pkg::MOTOR_LIMIT;
   localparam int BASE        = hhdm_pkg::PWM_BASE;
   localparam int ROLL_SHARE  = 3;
   localparam int IDLE_LIMIT  = 2000;
   localparam int REPORT_MAX  = 10;
   localparam int PHASE_TICKS = 130;

   // one control tick as presented on req_tdata
   typedef struct {
      logic                              start;
      logic                              armed;
      logic [hhdm_pkg::STICK_W-1:0]      roll;
      logic [hhdm_pkg::STICK_W-1:0]      thr;
      logic signed [hhdm_pkg::YAW_W-1:0] yaw;
   } stick_tick_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // [0] start_pilot, [1] armed, [12:2] roll_stick, [23:13] throttle_stick,
   // [32:24] yaw_angle, [39:33] zero
   logic [hhdm_pkg::REQ_W-1:0]  req_tdata = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // [10:0] left_pwm, [21:11] right_pwm, [22] left_reverse, [23] right_reverse
   logic [hhdm_pkg::RSP_W-1:0]  rsp_tdata;
   logic                        csr_wen = 1'b0;
   logic [0:0]                  csr_index = '0;
   logic [hhdm_pkg::BAND_W-1:0] csr_wdata = '0;

   // predictor copy of the block state and its registers
   int gain_now = int'(hhdm_pkg::GAIN_RESET);
   int band_now = int'(hhdm_pkg::BAND_RESET);
   int aim_heading = 0;
   logic left_back_held = 1'b0;
   logic right_back_held = 1'b0;

   // expected motor commands, oldest first
   hhdm_pkg::result_type motor_cmds_due[$];

   int   mismatch_count = 0;
   int   idle_cycles = 0;
   int   ready_stall_left = 0;
   int   yaw_drift = 0;
   // when set the side never idles, giving back-to-back stretches
   logic req_steady = 1'b0;
   logic rsp_steady = 1'b0;

   heading_hold_differential_mixer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int clamp_motor(int v);
      if (v < -LIMIT) return -LIMIT;
      if (v > LIMIT) return LIMIT;
      return v;
   endfunction

   // pwm pulse width for a clamped motor value, sign goes to the reverse bit
   function automatic logic [hhdm_pkg::PWM_W-1:0] motor_pwm(int v);
      int mag;
      mag = (v < 0) ? -v : v;
      return hhdm_pkg::PWM_W'(BASE + 2 * mag);
   endfunction

   // advances the predicted mixer state by one tick and returns its motor command
   function automatic hhdm_pkg::result_type mix_motors(stick_tick_type s);
      int yaw;
      int dev;
      int adev;
      int roll_dev;
      int err;
      int share;
      int left;
      int right;
      hhdm_pkg::result_type r;
      yaw = s.yaw;
      if (s.start) aim_heading = yaw;
      if (s.armed) begin
         // motors parked, direction bits hold from the last mixed tick
         r.left_pwm      = hhdm_pkg::PWM_BASE;
         r.right_pwm     = hhdm_pkg::PWM_BASE;
         r.left_reverse  = left_back_held;
         r.right_reverse = right_back_held;
         return r;
      end
      dev  = int'(s.roll) - CENTER;
      adev = (dev < 0) ? -dev : dev;
      if (adev < band_now) begin
         // heading hold: roll from the wrapped heading error
         err = aim_heading - yaw;
         if (err > HALF) err -= FULL;
         else if (err < -HALF) err += FULL;
         roll_dev = gain_now * err;
      end else begin
         roll_dev    = dev;
         aim_heading = yaw;
      end
      share = roll_dev / ROLL_SHARE;
      left  = clamp_motor(int'(s.thr) - CENTER + share);
      right = clamp_motor(int'(s.thr) - CENTER - share);
      left_back_held  = (left < 0);
      right_back_held = (right < 0);
      r.left_pwm      = motor_pwm(left);
      r.right_pwm     = motor_pwm(right);
      r.left_reverse  = left_back_held;
      r.right_reverse = right_back_held;
      return r;
   endfunction

   function automatic stick_tick_type make_tick(logic start, logic armed, int roll, int thr,
                                                int yaw);
      stick_tick_type s;
      s.start = start;
      s.armed = armed;
      s.roll  = hhdm_pkg::STICK_W'(roll);
      s.thr   = hhdm_pkg::STICK_W'(thr);
      s.yaw   = hhdm_pkg::YAW_W'(yaw);
      return s;
   endfunction

   // mostly flight-like ticks: roll near center, yaw drifting; some raw noise
   function automatic stick_tick_type random_tick();
      stick_tick_type s;
      int span;
      int pick;
      s.start = ($urandom_range(0, 9) == 0);
      s.armed = ($urandom_range(0, 6) == 0);
      span = band_now + 2;
      pick = int'($urandom_range(0, 9));
      if (pick == 0) s.roll = hhdm_pkg::STICK_W'($urandom_range(0, 2047));
      else if (pick <= 5)
         s.roll = hhdm_pkg::STICK_W'(CENTER - span + int'($urandom_range(0, 2 * span)));
      else s.roll = hhdm_pkg::STICK_W'($urandom_range(1000, 2000));
      if ($urandom_range(0, 9) == 0) s.thr = hhdm_pkg::STICK_W'($urandom_range(0, 2047));
      else s.thr = hhdm_pkg::STICK_W'($urandom_range(1000, 2000));
      if ($urandom_range(0, 9) == 0) begin
         s.yaw = hhdm_pkg::YAW_W'($urandom_range(0, 511));
      end else begin
         yaw_drift += int'($urandom_range(0, 20)) - 10;
         if (yaw_drift > HALF) yaw_drift -= FULL;
         else if (yaw_drift < -HALF) yaw_drift += FULL;
         s.yaw = hhdm_pkg::YAW_W'(yaw_drift);
      end
      return s;
   endfunction

   // sends one tick after a random gap and records its expected command
   task automatic drive_tick(stick_tick_type s);
      int gap;
      gap = req_steady ? 0 : int'($urandom_range(0, 10));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, s.yaw, s.thr, s.roll, s.armed, s.start};
      do @(posedge clock); while (!req_tready);
      motor_cmds_due.push_back(mix_motors(s));
   endtask

   // drop valid and let every outstanding command drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (motor_cmds_due.size() != 0) @(posedge clock);
   endtask

   // writes the gain register, then the deadband register, only while idle
   task automatic set_mixer_config(int gain, int band);
      csr_wen   <= 1'b1;
      csr_index <= hhdm_pkg::CSR_HEADING_GAIN;
      csr_wdata <= hhdm_pkg::BAND_W'(gain);
      @(posedge clock);
      csr_index <= hhdm_pkg::CSR_STICK_DEADBAND;
      csr_wdata <= hhdm_pkg::BAND_W'(band);
      @(posedge clock);
      csr_wen   <= 1'b0;
      gain_now = gain & 6'h3f;
      band_now = band & 9'h1ff;
   endtask

   function automatic void check_motor_cmd(hhdm_pkg::result_type got);
      hhdm_pkg::result_type want;
      if (motor_cmds_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("unexpected transaction on rsp_: %h", got);
         return;
      end
      want = motor_cmds_due.pop_front();
      if (got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm ||
          got.left_reverse !== want.left_reverse ||
          got.right_reverse !== want.right_reverse) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("motor command: expected L %0d/%b R %0d/%b, got L %0d/%b R %0d/%b",
                     want.left_pwm, want.left_reverse, want.right_pwm, want.right_reverse,
                     got.left_pwm, got.left_reverse, got.right_pwm, got.right_reverse);
      end
   endfunction

   // result side: check each transaction, then stall rsp_tready for a random count
   // also the watchdog on cycles where neither side moves a transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_stall_left = 0;
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            check_motor_cmd(hhdm_pkg::result_type'(rsp_tdata));
            ready_stall_left = rsp_steady ? 0 : int'($urandom_range(0, 10));
         end
         if (ready_stall_left > 0) begin
            rsp_tready <= 1'b0;
            ready_stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // reset config: latch, hold, wrap, deadband edges, armed hold, stick extremes
   task automatic test_directed_mixing();
      drive_tick(make_tick(1, 0, 1500, 1500, 45));   // start latch, zero error
      drive_tick(make_tick(0, 0, 1510, 1500, 90));   // hold turns left motor back
      drive_tick(make_tick(0, 1, 2000, 2000, 0));    // armed keeps the held bits
      drive_tick(make_tick(1, 1, 1500, 1500, -170)); // start latch while armed
      drive_tick(make_tick(0, 0, 1500, 1500, 170));  // error wraps from below
      drive_tick(make_tick(1, 0, 1500, 1500, 170));
      drive_tick(make_tick(0, 0, 1500, 1500, -170)); // error wraps from above
      drive_tick(make_tick(0, 0, 1530, 1500, 0));    // on deadband edge, stick wins
      drive_tick(make_tick(0, 0, 1529, 1500, 10));   // just inside the deadband
      drive_tick(make_tick(0, 0, 1470, 1500, 0));
      drive_tick(make_tick(0, 0, 1471, 1500, -256)); // yaw at its 9-bit minimum
      drive_tick(make_tick(1, 0, 1500, 1500, 255));  // yaw at its 9-bit maximum
      drive_tick(make_tick(0, 0, 1500, 1500, -256)); // widest error before wrap
      drive_tick(make_tick(0, 0, 2000, 2000, 0));    // left clamps high
      drive_tick(make_tick(0, 0, 1000, 1000, 0));    // left clamps low
      drive_tick(make_tick(0, 0, 0, 0, 0));          // sticks far under range
      drive_tick(make_tick(0, 0, 2047, 2047, 0));    // sticks at all ones
      drive_tick(make_tick(0, 0, 1500, 1750, 0));
   endtask

   // register extremes: big gain and deadband, then both at zero, then widest band
   task automatic test_config_extremes();
      wait_idle();
      set_mixer_config(63, 500);
      drive_tick(make_tick(1, 0, 1500, 1500, 0));
      drive_tick(make_tick(0, 0, 1001, 1500, 180));  // hold with large gain saturates
      drive_tick(make_tick(0, 0, 1000, 1500, 180));  // on deadband edge
      wait_idle();
      set_mixer_config(0, 0);
      drive_tick(make_tick(0, 0, 1500, 1500, 30));   // zero deadband, hold never acts
      drive_tick(make_tick(0, 1, 1500, 1200, 30));
      wait_idle();
      set_mixer_config(10, 511);
      drive_tick(make_tick(1, 0, 1000, 1300, -90));  // inside the widest deadband
   endtask

   // random flight over several register settings and idle patterns
   task automatic test_random_flight();
      int gain;
      int band;
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         gain = (p == 1) ? 63 : (p == 2) ? 0 : int'($urandom_range(1, 62));
         band = (p == 1) ? 500 : (p == 2) ? 0 : (p == 3) ? 511 : int'($urandom_range(1, 120));
         set_mixer_config(gain, band);
         req_steady = (p % 3 == 0);
         rsp_steady = (p % 4 == 1);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            // sender holds off mid-phase until the pipeline has drained
            if (p == 3 && i == PHASE_TICKS / 2) wait_idle();
            drive_tick(random_tick());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_mixing();
      test_config_extremes();
      test_random_flight();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
